// ===== src/idec_pkg.sv =====
// ----------------------------------------------------------------------------
// idec_pkg
// Shared widths, kind and operand form codes, and a helper for the decoder.
// ----------------------------------------------------------------------------
package idec_pkg;

    localparam int ADDR_BITS_DEF = 22;
    localparam int WORD_W        = 16;
    localparam int OUT_ADDR_W    = 22;
    localparam int CODE_W        = 4;
    localparam int REG_W         = 3;

    localparam logic [WORD_W-1:0] RETF_WORD = 16'h9a90;
    localparam logic [WORD_W-1:0] RETI_WORD = 16'h9a98;
    localparam logic [WORD_W-1:0] ONES_WORD = 16'hffff;

    localparam logic [CODE_W-1:0] K_INVALID  = 4'd0;
    localparam logic [CODE_W-1:0] K_UNKNOWN  = 4'd1;
    localparam logic [CODE_W-1:0] K_BRANCH   = 4'd2;
    localparam logic [CODE_W-1:0] K_CALL     = 4'd3;
    localparam logic [CODE_W-1:0] K_MULTIPLY = 4'd4;
    localparam logic [CODE_W-1:0] K_POP      = 4'd5;
    localparam logic [CODE_W-1:0] K_PUSH     = 4'd6;
    localparam logic [CODE_W-1:0] K_RETF     = 4'd7;
    localparam logic [CODE_W-1:0] K_RETI     = 4'd8;
    localparam logic [CODE_W-1:0] K_ALU      = 4'd9;
    localparam logic [CODE_W-1:0] K_STORE    = 4'd10;

    localparam logic [CODE_W-1:0] F_BP_DISP  = 4'd0;
    localparam logic [CODE_W-1:0] F_IMM6     = 4'd1;
    localparam logic [CODE_W-1:0] F_INDIRECT = 4'd2;
    localparam logic [CODE_W-1:0] F_REGISTER = 4'd3;
    localparam logic [CODE_W-1:0] F_IMM16    = 4'd4;
    localparam logic [CODE_W-1:0] F_DIRECT16 = 4'd5;
    localparam logic [CODE_W-1:0] F_DIR16_WB = 4'd6;
    localparam logic [CODE_W-1:0] F_ASR      = 4'd7;
    localparam logic [CODE_W-1:0] F_LSL      = 4'd8;
    localparam logic [CODE_W-1:0] F_LSR      = 4'd9;
    localparam logic [CODE_W-1:0] F_ROL      = 4'd10;
    localparam logic [CODE_W-1:0] F_ROR      = 4'd11;
    localparam logic [CODE_W-1:0] F_DIRECT6  = 4'd12;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] insn_address;
        logic [WORD_W-1:0]     first_word;
        logic [WORD_W-1:0]     second_word;
        logic                  has_second;
        logic [CODE_W-1:0]     kind;
        logic [CODE_W-1:0]     operand_form;
        logic [CODE_W-1:0]     alu_or_condition;
        logic [REG_W-1:0]      reg_dest;
        logic [REG_W-1:0]      reg_source;
        logic [OUT_ADDR_W-1:0] operand_value;
        logic [REG_W-1:0]      range_first;
        logic [REG_W-1:0]      range_last;
    } t_result;

    // first word that takes an extension word
    function automatic logic needs_ext(input logic [WORD_W-1:0] w);
        logic [3:0] op;
        logic [2:0] md;
        logic [2:0] nn;
        op = w[15:12];
        md = w[8:6];
        nn = w[5:3];
        return (op < 4'd14 && md == 3'd4 && nn >= 3'd1 && nn <= 3'd3) ||
               (op == 4'd15 && (md == 3'd1 || md == 3'd2));
    endfunction

endpackage

// ===== src/idec_ifs.sv =====
// ----------------------------------------------------------------------------
// idec channel interfaces
// Valid/ready channels for code words, decode results and the start address.
// ----------------------------------------------------------------------------
interface idec_in_if import idec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] code_word;

    modport source (output valid, output code_word, input ready);
    modport sink   (input valid, input code_word, output ready);
endinterface

interface idec_out_if import idec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OUT_ADDR_W-1:0] insn_address;
    logic [WORD_W-1:0]     first_word;
    logic [WORD_W-1:0]     second_word;
    logic                  has_second;
    logic [CODE_W-1:0]     kind;
    logic [CODE_W-1:0]     operand_form;
    logic [CODE_W-1:0]     alu_or_condition;
    logic [REG_W-1:0]      reg_dest;
    logic [REG_W-1:0]      reg_source;
    logic [OUT_ADDR_W-1:0] operand_value;
    logic [REG_W-1:0]      range_first;
    logic [REG_W-1:0]      range_last;

    modport source (
        output valid, output insn_address, output first_word, output second_word,
        output has_second, output kind, output operand_form, output alu_or_condition,
        output reg_dest, output reg_source, output operand_value,
        output range_first, output range_last, input ready
    );
    modport sink (
        input valid, input insn_address, input first_word, input second_word,
        input has_second, input kind, input operand_form, input alu_or_condition,
        input reg_dest, input reg_source, input operand_value,
        input range_first, input range_last, output ready
    );
endinterface

interface idec_cfg_if import idec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OUT_ADDR_W-1:0] start_address;

    modport source (output valid, output start_address, input ready);
    modport sink   (input valid, input start_address, output ready);
endinterface

// ===== src/sixteen_bit_isa_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// sixteen_bit_isa_instruction_decoder
// Decodes a stream of 16-bit instruction words, joining extension words.
//
//   port    dir   carries                      request
//   i_in    in    code_word                    one instruction or extension word
//   o_out   out   decoded fields (12)          one decoded instruction
//   i_cfg   in    start_address                load of the word address
//
// Input register, decode logic, result register; one word accepted per
// cycle while results are taken. A word that needs an extension is held and
// yields no result. Reset clears valids, the held word and the address.
// A stalled result holds its register; the input register keeps taking
// words until it too is full.
// ----------------------------------------------------------------------------
module sixteen_bit_isa_instruction_decoder
    import idec_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    idec_in_if.sink   i_in,
    idec_out_if.source o_out,
    idec_cfg_if.sink  i_cfg
);

    logic                 r_in_valid;
    logic [WORD_W-1:0]    r_in_word;
    logic                 r_await;
    logic [WORD_W-1:0]    r_held;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 out_free;
    logic                 gives_result;
    logic                 adv;
    logic [WORD_W-1:0]    dw;
    logic [WORD_W-1:0]    ext;
    logic                 has2;
    logic [ADDR_BITS-1:0] next_addr;
    logic [ADDR_BITS-1:0] tgt;
    logic [31:0]          tgt_wide;
    logic [31:0]          addr_wide;
    logic [31:0]          cfg_wide;
    t_result              n_out;

    logic [3:0] op;
    logic [2:0] ra;
    logic [2:0] md;
    logic [2:0] nn;
    logic [2:0] rb;
    logic [5:0] imm;
    logic       strict;
    logic [3:0] kind;
    logic [3:0] form;
    logic [2:0] rf;
    logic [2:0] rl;
    logic [OUT_ADDR_W-1:0] val;

    assign out_free     = !r_out_valid || o_out.ready;
    assign gives_result = r_await || !needs_ext(r_in_word);
    assign adv          = r_in_valid && (!gives_result || out_free);
    assign i_in.ready   = !r_in_valid || adv;
    assign i_cfg.ready  = 1'b1;

    assign dw   = r_await ? r_held : r_in_word;
    assign ext  = r_await ? r_in_word : '0;
    assign has2 = r_await;

    assign op  = dw[15:12];
    assign ra  = dw[11:9];
    assign md  = dw[8:6];
    assign nn  = dw[5:3];
    assign rb  = dw[2:0];
    assign imm = dw[5:0];

    assign next_addr = r_addr + ADDR_BITS'(has2 ? 2'd2 : 2'd1);
    assign tgt       = (md == 3'd0) ? next_addr + ADDR_BITS'(imm)
                                    : next_addr - ADDR_BITS'(imm);
    assign tgt_wide  = 32'(tgt);
    assign addr_wide = 32'(r_addr);
    assign cfg_wide  = 32'(i_cfg.start_address);

    always_comb begin
        kind   = K_UNKNOWN;
        form   = F_BP_DISP;
        rf     = '0;
        rl     = '0;
        val    = '0;
        strict = (op inside {4'd4, 4'd6, 4'd9, 4'd12}) && (ra != rb);
        if (dw == '0 || dw == ONES_WORD) begin
            kind = K_INVALID;
        end else if (op < 4'd15 && ra == 3'd7 && md <= 3'd1) begin
            kind = K_BRANCH;
            form = F_IMM6;
            val  = tgt_wide[OUT_ADDR_W-1:0];
        end else if (op == 4'd5 || op == 4'd7) begin
            kind = K_INVALID;
        end else if (op == 4'd14) begin
            kind = K_UNKNOWN;
        end else if (op == 4'd15) begin
            if (md == 3'd1 && ra == 3'd0) begin
                kind = K_CALL;
                val  = {imm, ext};
            end else if (md == 3'd4 && nn == 3'd1 && ra != 3'd7) begin
                kind = K_MULTIPLY;
                form = F_REGISTER;
            end else begin
                kind = K_UNKNOWN;
            end
        end else if (op == 4'd13) begin
            case (md)
                3'd0: begin
                    kind = K_STORE;
                    val  = OUT_ADDR_W'(imm);
                end
                3'd2: begin
                    if ({1'b0, ra} + 4'd1 >= {1'b0, nn} && {1'b0, ra} < {1'b0, nn} + 4'd7) begin
                        kind = K_PUSH;
                        form = F_INDIRECT;
                        rf   = ra + 3'd1 - nn;
                        rl   = ra;
                    end else begin
                        kind = K_INVALID;
                    end
                end
                3'd3: begin
                    kind = K_STORE;
                    form = F_INDIRECT;
                end
                3'd4: kind = K_UNKNOWN;
                3'd7: begin
                    kind = K_STORE;
                    form = F_DIRECT6;
                    val  = OUT_ADDR_W'(imm);
                end
                default: kind = K_INVALID;
            endcase
        end else begin
            kind = K_ALU;
            case (md)
                3'd0: begin
                    form = F_BP_DISP;
                    val  = OUT_ADDR_W'(imm);
                end
                3'd1: begin
                    form = F_IMM6;
                    val  = OUT_ADDR_W'(imm);
                end
                3'd2: begin
                    form = F_BP_DISP;
                    if (op != 4'd9) begin
                        kind = K_INVALID;
                    end else if (dw == RETF_WORD) begin
                        kind = K_RETF;
                    end else if (dw == RETI_WORD) begin
                        kind = K_RETI;
                    end else if (ra != 3'd7 && {1'b0, ra} + {1'b0, nn} < 4'd8) begin
                        kind = K_POP;
                        form = F_INDIRECT;
                        rf   = ra + 3'd1;
                        rl   = ra + nn;
                    end else begin
                        kind = K_INVALID;
                    end
                end
                3'd3: form = F_INDIRECT;
                3'd4: begin
                    if (nn == 3'd0) begin
                        form = F_REGISTER;
                    end else if (nn <= 3'd2) begin
                        if (strict) begin
                            kind = K_INVALID;
                        end else begin
                            form = (nn == 3'd1) ? F_IMM16 : F_DIRECT16;
                            val  = OUT_ADDR_W'(ext);
                        end
                    end else if (nn == 3'd3) begin
                        if (op == 4'd4 || op == 4'd12 || strict) begin
                            kind = K_INVALID;
                        end else begin
                            form = F_DIR16_WB;
                            val  = OUT_ADDR_W'(ext);
                        end
                    end else begin
                        form = F_ASR;
                        val  = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                    end
                end
                3'd5: begin
                    form = nn[2] ? F_LSR : F_LSL;
                    val  = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                end
                3'd6: begin
                    form = nn[2] ? F_ROR : F_ROL;
                    val  = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                end
                default: begin
                    form = F_DIRECT6;
                    val  = OUT_ADDR_W'(imm);
                end
            endcase
            if (kind == K_INVALID) begin
                form = F_BP_DISP;
            end
        end
    end

    always_comb begin
        n_out.insn_address     = addr_wide[OUT_ADDR_W-1:0];
        n_out.first_word       = dw;
        n_out.second_word      = ext;
        n_out.has_second       = has2;
        n_out.kind             = kind;
        n_out.operand_form     = form;
        n_out.alu_or_condition = op;
        n_out.reg_dest         = ra;
        n_out.reg_source       = rb;
        n_out.operand_value    = val;
        n_out.range_first      = rf;
        n_out.range_last       = rl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_await     <= 1'b0;
            r_held      <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                if (gives_result) begin
                    r_await <= 1'b0;
                end else begin
                    r_await <= 1'b1;
                    r_held  <= r_in_word;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_addr <= cfg_wide[ADDR_BITS-1:0];
            end else if (adv && gives_result) begin
                r_addr <= next_addr;
            end
            if (adv && gives_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.code_word;
        end
        if (adv && gives_result) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.insn_address     = r_out.insn_address;
    assign o_out.first_word       = r_out.first_word;
    assign o_out.second_word      = r_out.second_word;
    assign o_out.has_second       = r_out.has_second;
    assign o_out.kind             = r_out.kind;
    assign o_out.operand_form     = r_out.operand_form;
    assign o_out.alu_or_condition = r_out.alu_or_condition;
    assign o_out.reg_dest         = r_out.reg_dest;
    assign o_out.reg_source       = r_out.reg_source;
    assign o_out.operand_value    = r_out.operand_value;
    assign o_out.range_first      = r_out.range_first;
    assign o_out.range_last       = r_out.range_last;

    a_hold_sets_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !gives_result |=> r_await)
        else $error("held first word did not set await");

    a_ext_step_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_await && !i_cfg.valid |=>
            r_addr == ADDR_BITS'($past(r_addr) + ADDR_BITS'(2)))
        else $error("address did not advance by two after extension");

    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == K_INVALID |->
            r_out.operand_form == F_BP_DISP && r_out.operand_value == '0)
        else $error("invalid instruction carries operand data");

endmodule

// ===== sim/idec_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// idec_tb_pkg
// Opcode and addressing mode codes shared by the decoder testbench files.
// ----------------------------------------------------------------------------
package idec_tb_pkg;

    localparam logic [3:0] OP_CMP     = 4'd4;
    localparam logic [3:0] OP_RSVD5   = 4'd5;
    localparam logic [3:0] OP_NEG     = 4'd6;
    localparam logic [3:0] OP_RSVD7   = 4'd7;
    localparam logic [3:0] OP_LOAD    = 4'd9;
    localparam logic [3:0] OP_TEST    = 4'd12;
    localparam logic [3:0] OP_STORE   = 4'd13;
    localparam logic [3:0] OP_EXT14   = 4'd14;
    localparam logic [3:0] OP_MISC15  = 4'd15;

    localparam logic [2:0] MD_BP      = 3'd0;
    localparam logic [2:0] MD_IMM     = 3'd1;
    localparam logic [2:0] MD_IND     = 3'd2;
    localparam logic [2:0] MD_IND_INC = 3'd3;
    localparam logic [2:0] MD_EXT     = 3'd4;
    localparam logic [2:0] MD_SHR     = 3'd5;
    localparam logic [2:0] MD_ROT     = 3'd6;
    localparam logic [2:0] MD_DIR6    = 3'd7;

    localparam logic [2:0] REG_PC     = 3'd7;

endpackage

// ===== sim/idec_checker.sv =====
// ----------------------------------------------------------------------------
// idec_checker
// Watches the code word, result and start address channels, predicts each
// decoded instruction and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module idec_checker
    import idec_pkg::*;
    import idec_tb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    idec_in_if   i_in,
    idec_out_if  i_out,
    idec_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_BITS_DEF-1:0] cur_addr;
    logic                     ext_pending;
    logic [WORD_W-1:0]        held_first;
    t_result                  expected_decodes[$];
    int                       fail_total;

    function automatic logic takes_extension(input logic [WORD_W-1:0] w);
        return (w[15:12] < OP_EXT14 && w[8:6] == MD_EXT && w[5:3] >= 3'd1 && w[5:3] <= 3'd3)
            || (w[15:12] == OP_MISC15 && (w[8:6] == MD_IMM || w[8:6] == MD_IND));
    endfunction

    function automatic t_result predict_decode(input logic [WORD_W-1:0] w,
                                               input logic [WORD_W-1:0] ext,
                                               input logic has2,
                                               input logic [ADDR_BITS_DEF-1:0] addr);
        t_result                  r;
        logic [3:0]               op;
        logic [2:0]               ra;
        logic [2:0]               md;
        logic [2:0]               nn;
        logic [2:0]               rb;
        logic [5:0]               imm;
        logic [ADDR_BITS_DEF-1:0] nxt;
        logic                     strict;
        int                       ra_i;
        int                       nn_i;
        op   = w[15:12];
        ra   = w[11:9];
        md   = w[8:6];
        nn   = w[5:3];
        rb   = w[2:0];
        imm  = w[5:0];
        ra_i = int'(ra);
        nn_i = int'(nn);
        nxt  = addr + ADDR_BITS_DEF'(has2 ? 2 : 1);
        r = '0;
        r.insn_address     = addr;
        r.first_word       = w;
        r.second_word      = has2 ? ext : '0;
        r.has_second       = has2;
        r.alu_or_condition = op;
        r.reg_dest         = ra;
        r.reg_source       = rb;
        r.kind             = K_UNKNOWN;
        if (w == '0 || w == ONES_WORD) begin
            r.kind = K_INVALID;
        end else if (op != OP_MISC15 && ra == REG_PC && (md == MD_BP || md == MD_IMM)) begin
            r.kind          = K_BRANCH;
            r.operand_form  = F_IMM6;
            r.operand_value = (md == MD_BP) ? nxt + ADDR_BITS_DEF'(imm)
                                            : nxt - ADDR_BITS_DEF'(imm);
        end else if (op == OP_RSVD5 || op == OP_RSVD7) begin
            r.kind = K_INVALID;
        end else if (op == OP_EXT14) begin
            r.kind = K_UNKNOWN;
        end else if (op == OP_MISC15) begin
            if (md == MD_IMM && ra == 3'd0) begin
                r.kind          = K_CALL;
                r.operand_value = {imm, ext};
            end else if (md == MD_EXT && nn == 3'd1 && ra != REG_PC) begin
                r.kind         = K_MULTIPLY;
                r.operand_form = F_REGISTER;
            end
        end else if (op == OP_STORE) begin
            case (md)
                MD_BP: begin
                    r.kind          = K_STORE;
                    r.operand_value = OUT_ADDR_W'(imm);
                end
                MD_IND: begin
                    if (ra_i + 1 >= nn_i && ra_i < nn_i + 7) begin
                        r.kind         = K_PUSH;
                        r.operand_form = F_INDIRECT;
                        r.range_first  = ra + 3'd1 - nn;
                        r.range_last   = ra;
                    end else begin
                        r.kind = K_INVALID;
                    end
                end
                MD_IND_INC: begin
                    r.kind         = K_STORE;
                    r.operand_form = F_INDIRECT;
                end
                MD_EXT: r.kind = K_UNKNOWN;
                MD_DIR6: begin
                    r.kind          = K_STORE;
                    r.operand_form  = F_DIRECT6;
                    r.operand_value = OUT_ADDR_W'(imm);
                end
                default: r.kind = K_INVALID;
            endcase
        end else begin
            strict = (op == OP_CMP || op == OP_TEST || op == OP_NEG || op == OP_LOAD) && ra != rb;
            r.kind = K_ALU;
            case (md)
                MD_BP: r.operand_value = OUT_ADDR_W'(imm);
                MD_IMM: begin
                    r.operand_form  = F_IMM6;
                    r.operand_value = OUT_ADDR_W'(imm);
                end
                MD_IND: begin
                    if (op != OP_LOAD) begin
                        r.kind = K_INVALID;
                    end else if (w == RETF_WORD) begin
                        r.kind = K_RETF;
                    end else if (w == RETI_WORD) begin
                        r.kind = K_RETI;
                    end else if (ra_i + 1 < 8 && ra_i + nn_i < 8) begin
                        r.kind         = K_POP;
                        r.operand_form = F_INDIRECT;
                        r.range_first  = ra + 3'd1;
                        r.range_last   = ra + nn;
                    end else begin
                        r.kind = K_INVALID;
                    end
                end
                MD_IND_INC: r.operand_form = F_INDIRECT;
                MD_EXT: begin
                    if (nn == 3'd0) begin
                        r.operand_form = F_REGISTER;
                    end else if (nn <= 3'd2) begin
                        if (strict) begin
                            r.kind = K_INVALID;
                        end else begin
                            r.operand_form  = (nn == 3'd1) ? F_IMM16 : F_DIRECT16;
                            r.operand_value = OUT_ADDR_W'(ext);
                        end
                    end else if (nn == 3'd3) begin
                        if (op == OP_CMP || op == OP_TEST || strict) begin
                            r.kind = K_INVALID;
                        end else begin
                            r.operand_form  = F_DIR16_WB;
                            r.operand_value = OUT_ADDR_W'(ext);
                        end
                    end else begin
                        r.operand_form  = F_ASR;
                        r.operand_value = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                    end
                end
                MD_SHR: begin
                    r.operand_form  = nn[2] ? F_LSR : F_LSL;
                    r.operand_value = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                end
                MD_ROT: begin
                    r.operand_form  = nn[2] ? F_ROR : F_ROL;
                    r.operand_value = OUT_ADDR_W'({1'b0, nn[1:0]} + 3'd1);
                end
                default: begin
                    r.operand_form  = F_DIRECT6;
                    r.operand_value = OUT_ADDR_W'(imm);
                end
            endcase
            if (r.kind == K_INVALID) begin
                r.operand_form = F_BP_DISP;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_total++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    task automatic compare_decode(input t_result want, input t_result got);
        check_field("insn_address", 32'(want.insn_address), 32'(got.insn_address));
        check_field("first_word", 32'(want.first_word), 32'(got.first_word));
        check_field("second_word", 32'(want.second_word), 32'(got.second_word));
        check_field("has_second", 32'(want.has_second), 32'(got.has_second));
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("operand_form", 32'(want.operand_form), 32'(got.operand_form));
        check_field("alu_or_condition", 32'(want.alu_or_condition), 32'(got.alu_or_condition));
        check_field("reg_dest", 32'(want.reg_dest), 32'(got.reg_dest));
        check_field("reg_source", 32'(want.reg_source), 32'(got.reg_source));
        check_field("operand_value", 32'(want.operand_value), 32'(got.operand_value));
        check_field("range_first", 32'(want.range_first), 32'(got.range_first));
        check_field("range_last", 32'(want.range_last), 32'(got.range_last));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            cur_addr    = '0;
            ext_pending = 1'b0;
            held_first  = '0;
            expected_decodes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                cur_addr = i_cfg.start_address;
            end
            if (i_out.valid && i_out.ready) begin
                got.insn_address     = i_out.insn_address;
                got.first_word       = i_out.first_word;
                got.second_word      = i_out.second_word;
                got.has_second       = i_out.has_second;
                got.kind             = i_out.kind;
                got.operand_form     = i_out.operand_form;
                got.alu_or_condition = i_out.alu_or_condition;
                got.reg_dest         = i_out.reg_dest;
                got.reg_source       = i_out.reg_source;
                got.operand_value    = i_out.operand_value;
                got.range_first      = i_out.range_first;
                got.range_last       = i_out.range_last;
                if (expected_decodes.size() == 0) begin
                    fail_total++;
                    $error("unexpected decode result for word 0x%0h", got.first_word);
                end else begin
                    compare_decode(expected_decodes.pop_front(), got);
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (ext_pending) begin
                    ext_pending = 1'b0;
                    expected_decodes.push_back(
                        predict_decode(held_first, i_in.code_word, 1'b1, cur_addr));
                    cur_addr = cur_addr + ADDR_BITS_DEF'(2);
                end else if (takes_extension(i_in.code_word)) begin
                    held_first  = i_in.code_word;
                    ext_pending = 1'b1;
                end else begin
                    expected_decodes.push_back(
                        predict_decode(i_in.code_word, '0, 1'b0, cur_addr));
                    cur_addr = cur_addr + ADDR_BITS_DEF'(1);
                end
            end
        end
        o_pending    <= expected_decodes.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Decoder testbench: directed encodings, then weighted random code word
// streams under three idle/stall mixes, with start address reloads between.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idec_pkg::*;
    import idec_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk;
    logic        i_rst_n;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          cycle_count;
    int          fail_count;
    int          pending_count;
    logic [15:0] directed_words [26];

    idec_in_if  in_ch ();
    idec_out_if out_ch ();
    idec_cfg_if cfg_ch ();

    sixteen_bit_isa_instruction_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    idec_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sixteen_bit_isa_instruction_decoder] ERROR");
            $finish;
        end
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [15:0] rand_code_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(9))
            0, 1, 2: ;
            3: begin
                w[15:12] = 4'($urandom_range(14));
                w[11:9]  = REG_PC;
                w[8:6]   = $urandom_range(1) ? MD_BP : MD_IMM;
            end
            4: begin
                w[15:12] = OP_LOAD;
                w[8:6]   = MD_IND;
                if ($urandom_range(3) == 0) begin
                    w = $urandom_range(1) ? RETF_WORD : RETI_WORD;
                end
            end
            5: w[15:12] = OP_STORE;
            6: begin
                w[15:12] = OP_MISC15;
                if ($urandom_range(1)) begin
                    w[11:9] = 3'd0;
                    w[8:6]  = MD_IMM;
                end else begin
                    w[8:6] = MD_EXT;
                    w[5:3] = 3'd1;
                end
            end
            7: begin
                w[15:12] = 4'($urandom_range(13));
                w[8:6]   = MD_EXT;
            end
            8: w = $urandom_range(1) ? 16'h0000 : ONES_WORD;
            default: w[15:12] = OP_EXT14;
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [15:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.code_word <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic settle_all();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [OUT_ADDR_W-1:0] addr);
        settle_all();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.start_address <= addr;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_word(rand_code_word());
        end
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.code_word      <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.start_address <= '0;
        i_rst_n              <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 30;
        // word pairs: call, imm16, direct16 writeback, op13 unknown, op15 unknown
        directed_words = '{16'h0000, 16'hffff, 16'h0e3f, 16'h0e7f, 16'hf07f, 16'habcd,
                           16'hf108, 16'h9a90, 16'h9a98, 16'h9290, 16'hd493, 16'hd005,
                           16'hd1c5, 16'h0908, 16'h1234, 16'h0118, 16'hffff, 16'h0120,
                           16'h0168, 16'h01b8, 16'he123, 16'hd108, 16'h0000, 16'h5001,
                           16'hf080, 16'h5555};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) send_word(directed_words[i]);

        write_start(22'h3fffff);
        tx_idle_pct  = 12;
        rx_stall_pct = 88;
        run_random(150);

        write_start(22'h000000);
        tx_idle_pct  = 88;
        rx_stall_pct = 12;
        run_random(150);

        write_start(OUT_ADDR_W'($urandom_range(22'h3fffff)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(75);
        settle_all();
        run_random(75);

        settle_all();
        if (fail_count == 0) begin
            $display("[sixteen_bit_isa_instruction_decoder] OK");
        end else begin
            $display("[sixteen_bit_isa_instruction_decoder] ERROR");
        end
        $finish;
    end

endmodule
